// ----- hdl/rtdl_pkg.sv -----
// rtdl_pkg: shared constants, codes and types of the rtd table linearizer
`timescale 1ns / 1ps

package rtdl_pkg;

  localparam int POINTS_DEF = 15;

  localparam int RES_W  = 16;
  localparam int IDX_W  = 4;
  localparam int BASE_W = 8;
  localparam int STEP_W = 6;
  localparam int TEMP_W = 19;
  localparam int STAT_W = 3;
  localparam int FRAC_W = 8;
  localparam int QUOT_W = STEP_W + FRAC_W;
  localparam int PROD_W = RES_W + STEP_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONV = 1'b1;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_INTERP = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EXACT  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BELOW  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ABOVE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ZSPAN  = 3'd4;

  typedef struct packed {
    logic              start;
    logic [RES_W-1:0]  diff;
    logic [RES_W-1:0]  span;
    logic [STEP_W-1:0] step;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hdl/rtd_table_linearizer.sv -----
// rtd_table_linearizer: breakpoint table, search sequencer and result register
`timescale 1ns / 1ps

// Converts an RTD resistance (unsigned 8.8 ohms) into temperature (signed 11.8 degrees)
// by piecewise-linear lookup in a table of POINTS calibrated breakpoints, which the
// user must load in ascending order by load transactions (tuser 0) before any convert
// transaction (tuser 1); the block itself does not enforce this. A load returns
// nothing. A convert checks the first and last entries, then binary-searches the
// table through the single table read port, one probe per cycle, and on an
// interpolation runs a bit-serial multiply by the step followed by a restoring divide
// of one quotient bit per cycle. One item is worked on at a time; the next is taken
// while a finished result waits at the output, and a result that finds the output
// still full holds the sequencer until the output drains.

module rtd_table_linearizer #(
  parameter int POINTS = rtdl_pkg::POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // entry_index[3:0], resistance[19:4]
  input  logic [0:0]  s_axis_tuser,   // command[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // temperature[18:0]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int AW    = $clog2(POINTS);
  localparam int IW    = (AW > rtdl_pkg::IDX_W) ? AW : rtdl_pkg::IDX_W;
  localparam int KS_W  = AW + rtdl_pkg::STEP_W;
  localparam int DEG_W = KS_W + 2;
  localparam int SUM_W = (DEG_W + rtdl_pkg::FRAC_W + 1 > rtdl_pkg::TEMP_W + 1) ?
                         DEG_W + rtdl_pkg::FRAC_W + 1 : rtdl_pkg::TEMP_W + 1;

  localparam logic [AW-1:0] LAST = AW'(POINTS - 1);
  localparam logic [AW-1:0] MID0 = AW'((POINTS - 1) / 2);

  localparam logic signed [SUM_W-1:0] TEMP_MAX = SUM_W'(262143);
  localparam logic signed [SUM_W-1:0] TEMP_MIN = -SUM_W'(262144);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK0 = 3'd1;
  localparam logic [2:0] ST_CHKN = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_DEG  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // configuration
  logic [rtdl_pkg::BASE_W-1:0] base_q;
  logic [rtdl_pkg::STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 8'hC4;
      step_q <= 6'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rtdl_pkg::CFG_BASE: base_q <= cfg_data_i;
        rtdl_pkg::CFG_STEP: step_q <= cfg_data_i[rtdl_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic                       in_acc;
  logic                       in_cmd;
  logic [rtdl_pkg::IDX_W-1:0] in_idx;
  logic [rtdl_pkg::RES_W-1:0] in_res;
  logic [IW-1:0]              idx_w;
  logic                       wr_en;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_cmd = s_axis_tuser[0];
  assign in_idx = s_axis_tdata[3:0];
  assign in_res = s_axis_tdata[19:4];
  assign idx_w  = IW'(in_idx);
  assign wr_en  = in_acc && (in_cmd == rtdl_pkg::CMD_LOAD) && (32'(idx_w) < 32'(POINTS));

  // breakpoint table
  logic [rtdl_pkg::RES_W-1:0] mem [POINTS];
  logic [rtdl_pkg::RES_W-1:0] rdata_q;
  logic [AW-1:0]              raddr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_w[AW-1:0]] <= in_res;
    end
    rdata_q <= mem[raddr];
  end

  // search state
  logic [2:0]                  state_q, state_d;
  logic [rtdl_pkg::RES_W-1:0]  res_q, res_d;
  logic [AW-1:0]               lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, k_q, k_d;
  logic [rtdl_pkg::RES_W-1:0]  flo_q, flo_d, fhi_q, fhi_d;
  logic                        eq0_q, eq0_d;
  logic [rtdl_pkg::STAT_W-1:0] stat_q, stat_d;
  logic signed [DEG_W-1:0]     deg_q, deg_d;
  logic [rtdl_pkg::QUOT_W-1:0] quot_q, quot_d;

  logic                        r_lt, r_gt;
  logic [AW-1:0]               lo_n, hi_n, mid_n;
  logic [AW:0]                 mid_sum;
  logic [KS_W-1:0]             kstep;

  logic                        m_valid_q, m_valid_d;
  logic [rtdl_pkg::TEMP_W-1:0] m_temp_q, m_temp_d;
  logic [rtdl_pkg::STAT_W-1:0] m_stat_q, m_stat_d;

  logic signed [SUM_W-1:0]     deg_ext, sum;
  logic [rtdl_pkg::TEMP_W-1:0] temp_sat;

  rtdl_pkg::div_req_t div_req;
  rtdl_pkg::div_rsp_t div_rsp;

  assign r_lt    = res_q < rdata_q;
  assign r_gt    = res_q > rdata_q;
  assign lo_n    = r_gt ? mid_q : lo_q;
  assign hi_n    = r_lt ? mid_q : hi_q;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = mid_sum[AW:1];
  assign kstep   = KS_W'(k_q) * KS_W'(step_q);

  assign deg_ext = SUM_W'(deg_q);
  assign sum     = (deg_ext <<< rtdl_pkg::FRAC_W) + signed'(SUM_W'(quot_q));

  always_comb begin
    if (sum > TEMP_MAX) begin
      temp_sat = TEMP_MAX[rtdl_pkg::TEMP_W-1:0];
    end else if (sum < TEMP_MIN) begin
      temp_sat = TEMP_MIN[rtdl_pkg::TEMP_W-1:0];
    end else begin
      temp_sat = sum[rtdl_pkg::TEMP_W-1:0];
    end
  end

  assign div_req.start = (state_q == ST_DEG) && (stat_q == rtdl_pkg::STAT_INTERP) &&
                         (fhi_q != flo_q);
  assign div_req.diff  = res_q - flo_q;
  assign div_req.span  = fhi_q - flo_q;
  assign div_req.step  = step_q;

  rtdl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    k_d       = k_q;
    flo_d     = flo_q;
    fhi_d     = fhi_q;
    eq0_d     = eq0_q;
    stat_d    = stat_q;
    deg_d     = deg_q;
    quot_d    = quot_q;
    raddr     = '0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_temp_d  = m_temp_q;
    m_stat_d  = m_stat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_cmd == rtdl_pkg::CMD_CONV)) begin
          res_d   = in_res;
          state_d = ST_CHK0;
        end
      end
      ST_CHK0: begin
        raddr = LAST;
        if (r_lt) begin
          k_d     = '0;
          stat_d  = rtdl_pkg::STAT_BELOW;
          state_d = ST_DEG;
        end else begin
          eq0_d   = !r_gt;
          flo_d   = rdata_q;
          state_d = ST_CHKN;
        end
      end
      ST_CHKN: begin
        raddr = MID0;
        if (r_gt) begin
          k_d     = LAST;
          stat_d  = rtdl_pkg::STAT_ABOVE;
          state_d = ST_DEG;
        end else if (eq0_q) begin
          k_d     = '0;
          stat_d  = rtdl_pkg::STAT_EXACT;
          state_d = ST_DEG;
        end else if (!r_lt) begin
          k_d     = LAST;
          stat_d  = rtdl_pkg::STAT_EXACT;
          state_d = ST_DEG;
        end else begin
          fhi_d   = rdata_q;
          lo_d    = '0;
          hi_d    = LAST;
          mid_d   = MID0;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        raddr = mid_n;
        if (!r_lt && !r_gt) begin
          k_d     = mid_q;
          stat_d  = rtdl_pkg::STAT_EXACT;
          state_d = ST_DEG;
        end else begin
          lo_d  = lo_n;
          hi_d  = hi_n;
          mid_d = mid_n;
          if (r_gt) begin
            flo_d = rdata_q;
          end else begin
            fhi_d = rdata_q;
          end
          if (hi_n - lo_n == AW'(1)) begin
            k_d     = lo_n;
            stat_d  = rtdl_pkg::STAT_INTERP;
            state_d = ST_DEG;
          end
        end
      end
      ST_DEG: begin
        deg_d  = DEG_W'(signed'(base_q)) + signed'(DEG_W'(kstep));
        quot_d = '0;
        if (div_req.start) begin
          state_d = ST_DIV;
        end else begin
          if ((stat_q == rtdl_pkg::STAT_INTERP) && (fhi_q == flo_q)) begin
            stat_d = rtdl_pkg::STAT_ZSPAN;
          end
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          quot_d  = div_rsp.quot;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_temp_d  = temp_sat;
          m_stat_d  = stat_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    k_q      <= k_d;
    flo_q    <= flo_d;
    fhi_q    <= fhi_d;
    eq0_q    <= eq0_d;
    stat_q   <= stat_d;
    deg_q    <= deg_d;
    quot_q   <= quot_d;
    m_temp_q <= m_temp_d;
    m_stat_q <= m_stat_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(24 - rtdl_pkg::TEMP_W){1'b0}}, m_temp_q};
  assign m_axis_tuser  = m_stat_q;

  // search window always brackets the probe
  a_srch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q < mid_q) && (mid_q < hi_q))
    else $error("search probe outside bracket");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide state");

  // divider runs only while the sequencer waits for it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

  // a result appears only from the final state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside final state");

  // a load never starts a conversion
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_cmd == rtdl_pkg::CMD_LOAD)) |=> (state_q == ST_IDLE))
    else $error("load left the idle state");

endmodule

// ----- hdl/rtdl_div.sv -----
// rtdl_div: bit-serial multiply by step and restoring divide by span
`timescale 1ns / 1ps

module rtdl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtdl_pkg::div_req_t  req_i,
  output rtdl_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(rtdl_pkg::QUOT_W);
  localparam int NUM_W = rtdl_pkg::PROD_W + rtdl_pkg::FRAC_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]                     phase_q, phase_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [rtdl_pkg::PROD_W-1:0]    acc_q, acc_d;
  logic [rtdl_pkg::PROD_W-1:0]    mcand_q, mcand_d;
  logic [rtdl_pkg::STEP_W-1:0]    mplier_q, mplier_d;
  logic [rtdl_pkg::RES_W-1:0]     span_q, span_d;
  logic [rtdl_pkg::RES_W-1:0]     rem_q, rem_d;
  logic [rtdl_pkg::QUOT_W-1:0]    nsh_q, nsh_d;

  logic [rtdl_pkg::PROD_W-1:0]    acc_nx;
  logic [NUM_W-1:0]               num;
  logic [rtdl_pkg::RES_W:0]       shifted;
  logic [rtdl_pkg::RES_W+1:0]     trial;

  assign acc_nx  = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign num     = {acc_nx, {rtdl_pkg::FRAC_W{1'b0}}};
  assign shifted = {rem_q, nsh_q[rtdl_pkg::QUOT_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, span_q};

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    span_d   = span_q;
    rem_d    = rem_q;
    nsh_d    = nsh_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          acc_d    = '0;
          mcand_d  = rtdl_pkg::PROD_W'(req_i.diff);
          mplier_d = req_i.step;
          span_d   = req_i.span;
          cnt_d    = CNT_W'(rtdl_pkg::STEP_W - 1);
          phase_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        acc_d    = acc_nx;
        mcand_d  = {mcand_q[rtdl_pkg::PROD_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[rtdl_pkg::STEP_W-1:1]};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // quotient fits QUOT_W bits, so the top of the numerator is below span
          rem_d   = num[NUM_W-1:rtdl_pkg::QUOT_W];
          nsh_d   = num[rtdl_pkg::QUOT_W-1:0];
          cnt_d   = CNT_W'(rtdl_pkg::QUOT_W - 1);
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        if (!trial[rtdl_pkg::RES_W+1]) begin
          rem_d = trial[rtdl_pkg::RES_W-1:0];
          nsh_d = {nsh_q[rtdl_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[rtdl_pkg::RES_W-1:0];
          nsh_d = {nsh_q[rtdl_pkg::QUOT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    span_q   <= span_d;
    rem_q    <= rem_d;
    nsh_q    <= nsh_d;
  end

  assign rsp_o.busy = (phase_q != PH_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = nsh_q;

endmodule

// ----- tb/rtd_table_linearizer_tb.sv -----
// rtd_table_linearizer_tb: self-checking stream testbench for the rtd table linearizer
`timescale 1ns / 1ps

module rtd_table_linearizer_tb;

  localparam int POINTS      = rtdl_pkg::POINTS_DEF;
  localparam int DRAIN_CYCLS = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                       cmd;
    logic [rtdl_pkg::IDX_W-1:0] idx;
    logic [rtdl_pkg::RES_W-1:0] res;
  } rtd_req_t;

  typedef struct packed {
    logic [rtdl_pkg::TEMP_W-1:0] temp;
    logic [rtdl_pkg::STAT_W-1:0] status;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = rtdl_pkg::CFG_BASE;
  logic [7:0]  cfg_data_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;
  logic [0:0]  s_axis_tuser = rtdl_pkg::CMD_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  rtd_table_linearizer #(
    .POINTS(POINTS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state, updated in transaction order
  logic [rtdl_pkg::RES_W-1:0] bp_table [POINTS];
  int               base_deg = -60;
  int               step_deg = 10;

  // table as the stimulus generator expects it once its queued loads land
  logic [rtdl_pkg::RES_W-1:0] plan_table [POINTS];

  rtd_req_t feed_q [$];
  reading_t due_readings [$];
  rtd_req_t cur_req;
  reading_t exp_r;
  reading_t got_r;

  int burst_left = 1;
  int gap_left = 0;
  int rdy_mode = 0;
  int rdy_cnt = 0;
  int err_cnt = 0;
  int n_load = 0;
  int n_conv = 0;
  int n_checked = 0;
  int n_settings = 1;
  int stat_cnt [8] = '{default: 0};

  function automatic longint point_temp(input int k);
    return (longint'(base_deg) + longint'(k) * longint'(step_deg)) * 256;
  endfunction

  function automatic reading_t linearize(input logic [rtdl_pkg::RES_W-1:0] r);
    reading_t o;
    int       lo;
    int       hi;
    int       mid;
    bit       hit;
    longint   t;
    longint   span;
    longint   num;
    lo  = 0;
    hi  = POINTS - 1;
    hit = 1'b0;
    if (r < bp_table[0]) begin
      t = point_temp(0);
      o.status = rtdl_pkg::STAT_BELOW;
    end else if (r > bp_table[hi]) begin
      t = point_temp(hi);
      o.status = rtdl_pkg::STAT_ABOVE;
    end else if (r == bp_table[0]) begin
      t = point_temp(0);
      o.status = rtdl_pkg::STAT_EXACT;
    end else if (r == bp_table[hi]) begin
      t = point_temp(hi);
      o.status = rtdl_pkg::STAT_EXACT;
    end else begin
      mid = (POINTS - 1) / 2;
      while (hi - lo != 1 && !hit) begin
        if (r < bp_table[mid]) begin
          hi = mid;
        end else if (r > bp_table[mid]) begin
          lo = mid;
        end else begin
          hit = 1'b1;
        end
        if (!hit) mid = (lo + hi) / 2;
      end
      if (hit) begin
        t = point_temp(mid);
        o.status = rtdl_pkg::STAT_EXACT;
      end else begin
        t    = point_temp(lo);
        span = longint'(bp_table[hi]) - longint'(bp_table[lo]);
        if (span == 0) begin
          o.status = rtdl_pkg::STAT_ZSPAN;
        end else begin
          // truncated quotient, sign follows the operands
          num = (longint'(r) - longint'(bp_table[lo])) * longint'(step_deg) * 256;
          t = t + num / span;
          o.status = rtdl_pkg::STAT_INTERP;
        end
      end
    end
    if (t > 262143) t = 262143;
    if (t < -262144) t = -262144;
    o.temp = t[rtdl_pkg::TEMP_W-1:0];
    return o;
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < MAX_REPORTS) $display("%s", msg);
    err_cnt++;
  endfunction

  function automatic void queue_load(input int idx, input int val);
    rtd_req_t it;
    it.cmd = rtdl_pkg::CMD_LOAD;
    it.idx = idx[rtdl_pkg::IDX_W-1:0];
    it.res = val[rtdl_pkg::RES_W-1:0];
    feed_q.push_back(it);
    if (idx < POINTS) plan_table[idx] = it.res;
  endfunction

  function automatic void queue_conv(input int val);
    rtd_req_t it;
    it.cmd = rtdl_pkg::CMD_CONV;
    it.idx = rtdl_pkg::IDX_W'($urandom_range(0, 15));
    it.res = val[rtdl_pkg::RES_W-1:0];
    feed_q.push_back(it);
  endfunction

  function automatic int pick_measure();
    int k;
    int lo_v;
    int hi_v;
    int v;
    k    = $urandom_range(0, POINTS - 2);
    lo_v = int'(plan_table[k]);
    hi_v = int'(plan_table[k + 1]);
    case ($urandom_range(0, 9))
      0: v = int'(plan_table[$urandom_range(0, POINTS - 1)]);
      1: v = $urandom_range(0, 1) ? lo_v + 1 : lo_v - 1;
      2: v = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : 65535)
                                         : $urandom_range(0, 65535);
      3: v = $urandom_range(0, 1) ? int'(plan_table[0]) - 1
                                  : int'(plan_table[POINTS - 1]) + 1;
      default: v = (hi_v >= lo_v) ? $urandom_range(lo_v, hi_v) : $urandom_range(hi_v, lo_v);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic void load_table(input int kind);
    int vals [POINTS];
    int order [POINTS];
    int acc;
    int j;
    int tmp;
    acc = 0;
    for (int k = 0; k < POINTS; k++) begin
      case (kind)
        0: begin
          if (k == 0) acc = $urandom_range(0, 16'h2000);
          else acc += $urandom_range(1, 16'h0FFF);
        end
        1: begin
          // roughly a platinum sensor curve
          if (k == 0) acc = 16'h4C00 + $urandom_range(0, 255);
          else acc += $urandom_range(980, 1000);
        end
        2: begin
          if (k == 0) acc = $urandom_range(0, 16'h1000);
          else acc += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16'h0FFF);
        end
        3: acc = (k == POINTS - 1) ? 65535 : k * (65535 / (POINTS - 1));
        4: acc = $urandom_range(0, 65535);
        default: begin
          if (k == 0) acc = $urandom_range(0, 16'hF000);
          else acc += $urandom_range(1, 3);
        end
      endcase
      vals[k]  = acc;
      order[k] = k;
    end
    for (int k = POINTS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < POINTS; k++) queue_load(order[k], vals[order[k]]);
  endfunction

  function automatic void run_random(input int n);
    int k;
    int lo_v;
    int hi_v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: queue_load(15, $urandom_range(0, 65535));
        1: queue_load($urandom_range(0, POINTS - 1), $urandom_range(0, 65535));
        2: begin
          k    = $urandom_range(0, POINTS - 1);
          lo_v = (k > 0) ? int'(plan_table[k - 1]) : 0;
          hi_v = (k < POINTS - 1) ? int'(plan_table[k + 1]) : 65535;
          queue_load(k, (lo_v <= hi_v) ? $urandom_range(lo_v, hi_v) : $urandom_range(0, 65535));
        end
        default: queue_conv(pick_measure());
      endcase
    end
  endfunction

  task automatic wait_drained();
    while (feed_q.size() != 0 || s_axis_tvalid || due_readings.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLS) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // source side: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_req.cmd == rtdl_pkg::CMD_LOAD) begin
          n_load++;
          if (cur_req.idx < POINTS) bp_table[cur_req.idx] = cur_req.res;
        end else begin
          n_conv++;
          due_readings.push_back(linearize(cur_req.res));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || feed_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, cur_req.res, cur_req.idx};
          s_axis_tuser  <= cur_req.cmd;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // sink side: checks each result transaction, stalls in changing patterns
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.temp   = m_axis_tdata[rtdl_pkg::TEMP_W-1:0];
        got_r.status = m_axis_tuser;
        stat_cnt[got_r.status]++;
        if (due_readings.size() == 0) begin
          note_error($sformatf("unexpected result: temperature %0d status %0d",
                               $signed(got_r.temp), got_r.status));
        end else begin
          exp_r = due_readings.pop_front();
          if (got_r.temp !== exp_r.temp || got_r.status !== exp_r.status) begin
            note_error($sformatf(
              "result %0d mismatch: temperature exp %0d got %0d, status exp %0d got %0d",
              n_checked, $signed(exp_r.temp), $signed(got_r.temp), exp_r.status,
              got_r.status));
          end
          n_checked++;
        end
      end
      if (rdy_cnt <= 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_cnt  = $urandom_range(20, 120);
      end
      rdy_cnt--;
      case (rdy_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (rdy_cnt % 5 == 0);
      endcase
    end
  end

  initial begin
    int b;
    int s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ascending table at reset settings, ignored load, clamps, hits, interpolation
    for (int k = POINTS - 1; k >= 0; k--) queue_load(k, 16'h4C00 + k * 1000);
    queue_load(15, 65535);
    queue_conv(0);
    queue_conv(65535);
    queue_conv(plan_table[0]);
    queue_conv(plan_table[POINTS - 1]);
    queue_conv(plan_table[7]);
    queue_conv(plan_table[3] + 1);
    queue_conv(plan_table[10] - 1);
    queue_conv(plan_table[0] - 1);
    run_random(120);

    for (int p = 1; p <= 8; p++) begin
      wait_drained();
      case (p)
        1: begin b = -128; s = 63; end
        2: begin b = 127;  s = 63; end
        3: begin b = 127;  s = 1;  end
        4: begin b = -128; s = 1;  end
        5: begin b = 0;    s = 0;  end
        default: begin
          b = int'($urandom_range(0, 255)) - 128;
          s = $urandom_range(1, 63);
        end
      endcase
      write_reg(rtdl_pkg::CFG_BASE, b[7:0]);
      base_deg = b;
      write_reg(rtdl_pkg::CFG_STEP, 8'(s));
      step_deg = s;
      n_settings++;
      @(negedge clk_i);
      load_table(p % 6);
      run_random(135);
    end
    wait_drained();

    $display("covered %0d loads and %0d conversions (%0d checked) over %0d register settings",
             n_load, n_conv, n_checked, n_settings);
    $display("status mix: %0d interpolated, %0d exact, %0d below, %0d above, %0d zero span",
             stat_cnt[rtdl_pkg::STAT_INTERP], stat_cnt[rtdl_pkg::STAT_EXACT],
             stat_cnt[rtdl_pkg::STAT_BELOW], stat_cnt[rtdl_pkg::STAT_ABOVE],
             stat_cnt[rtdl_pkg::STAT_ZSPAN]);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
